// ===== rtl/core/sql_like_pattern_matcher_macros.svh =====
// assertion macros for the sql like pattern matcher
`ifndef SQL_LIKE_PATTERN_MATCHER_MACROS_SVH
`define SQL_LIKE_PATTERN_MATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that holds at every clock edge out of reset
`define SLPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that implies a consequence in the next cycle
`define SLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SLPM_ASSERT(lbl, prop, msg)
`define SLPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/slpm_pkg.sv =====
// types, codes and helpers shared by the sql like pattern matcher
package slpm_pkg;

  // opcodes of an input transaction
  localparam logic [1:0] OP_PATTERN = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  // pattern metacharacters
  localparam logic [7:0] CHAR_PERCENT   = 8'h25;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ONE = 2'd1,
    KIND_SEQ = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] lit;
  } token_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       pattern_start;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_error;
  } out_item_t;

  // continuation bytes that follow a lead byte
  function automatic logic [1:0] char_rest(input logic utf8, input logic [7:0] b);
    logic [1:0] rest;
    rest = 2'd0;
    if (utf8) begin
      if (b[7:5] == 3'b110) begin
        rest = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        rest = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        rest = 2'd3;
      end
    end
    return rest;
  endfunction

endpackage

// ===== rtl/core/slpm_engine.sv =====
// bit-parallel position update and percent closure for one text byte or end of text
module slpm_engine #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                                     utf8_mode,
  input  logic                                     is_text,
  input  logic [7:0]                               text_byte,
  input  logic [$clog2(PATTERN_MAX+1)-1:0]         token_count,
  input  slpm_pkg::token_t [PATTERN_MAX-1:0]       tokens,
  input  logic [PATTERN_MAX:0]                     active,
  input  logic [PATTERN_MAX:0][1:0]                skip,
  output logic [PATTERN_MAX:0]                     active_nxt,
  output logic [PATTERN_MAX:0][1:0]                skip_nxt,
  output logic                                     hit
);
  import slpm_pkg::*;

  localparam int NPOS = PATTERN_MAX + 1;
  localparam int CW   = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0] tok_valid;
  logic [PATTERN_MAX-1:0] seq_m;
  logic [PATTERN_MAX-1:0] one_m;
  logic [PATTERN_MAX-1:0] lit_m;
  logic [NPOS-1:0]        from_one;
  logic [NPOS-1:0]        from_seq;
  logic [NPOS-1:0]        from_lit;
  logic [NPOS-1:0]        wild;
  logic [NPOS-1:0]        skip_nz;
  logic [NPOS-1:0]        act_step;
  logic [NPOS-1:0]        clo_in;
  logic [NPOS-1:0]        prop_m;
  logic [NPOS-1:0]        gen_m;
  logic [NPOS:0]          clo_sum;
  logic [NPOS:0]          clo_carry;
  logic [1:0]             rest;
  logic [1:0]             sk_a;
  logic [1:0]             sk_b;

  assign rest = char_rest(utf8_mode, text_byte);

  // per-token kind masks, limited to the loaded pattern
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      tok_valid[i] = CW'(i) < token_count;
      seq_m[i] = tok_valid[i] && (tokens[i].kind == KIND_SEQ);
      one_m[i] = tok_valid[i] && (tokens[i].kind == KIND_ONE);
      lit_m[i] = tok_valid[i] && (tokens[i].kind == KIND_LIT) && (tokens[i].lit == text_byte);
    end
  end

  // moves into each position from the token before it or the token at it
  assign from_one = {one_m & active[PATTERN_MAX-1:0], 1'b0};
  assign from_lit = {lit_m & active[PATTERN_MAX-1:0], 1'b0};
  assign from_seq = {1'b0, seq_m & active[PATTERN_MAX-1:0]};
  assign wild     = from_one | from_seq;

  // new active bits and continuation counts, one position at a time
  always_comb begin
    for (int j = 0; j < NPOS; j++) begin
      skip_nz[j]  = skip[j] != 2'd0;
      act_step[j] = (skip[j] == 2'd1) || from_lit[j] || (wild[j] && (rest == 2'd0));
      sk_a = (skip[j] > 2'd1) ? skip[j] - 2'd1 : 2'd0;
      sk_b = (wild[j] && (rest != 2'd0)) ? rest : 2'd0;
      skip_nxt[j] = (sk_a > sk_b) ? sk_a : sk_b;
    end
  end

  // closure over percent runs as a carry chain: percent tokens propagate
  assign clo_in    = is_text ? act_step : (active | skip_nz);
  assign prop_m    = {1'b0, seq_m};
  assign gen_m     = prop_m & clo_in;
  assign clo_sum   = {1'b0, prop_m} + {1'b0, gen_m};
  assign clo_carry = clo_sum ^ {1'b0, prop_m} ^ {1'b0, gen_m};
  assign active_nxt = clo_in | clo_carry[NPOS-1:0];

  // whole text consumed when the end position is reached
  assign hit = active_nxt[token_count];

endmodule

// ===== rtl/core/sql_like_pattern_matcher.sv =====
// top level of the sql like pattern matcher
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    in_data   (opcode, data_byte, pattern_start)
//  out_     output     out_valid / out_ready  out_data  (matched, pattern_error)
//  cfg_     input      cfg_valid / cfg_ready  cfg_data  (utf8_mode)
//
// one transaction per cycle while no end-of-text transaction is stalled; each one sits in
// the input register while the position update and percent closure (one carry chain) run,
// and a result is registered in the result register once its end-of-text transaction leaves it.
// reset loads an empty pattern; the token store is not cleared and is read only below
// the token count. an end-of-text transaction waits in the input register while the
// result register is full and not taken; other opcodes never stall.
`include "sql_like_pattern_matcher_macros.svh"

module sql_like_pattern_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  slpm_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output slpm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import slpm_pkg::*;

  localparam int NPOS = PATTERN_MAX + 1;
  localparam int CW   = $clog2(PATTERN_MAX + 1);
  localparam int IW   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic                      utf8_r;
  logic                      in_vld_r;
  in_item_t                  in_r;
  logic                      out_vld_r;
  out_item_t                 out_r;
  token_t [PATTERN_MAX-1:0]  tok_r;
  logic [CW-1:0]             count_r;
  logic                      esc_r;
  logic                      ovf_r;
  logic [NPOS-1:0]           lead_r;
  logic [NPOS-1:0]           act_r;
  logic [NPOS-1:0][1:0]      skip_r;

  logic [CW-1:0]             count_nxt;
  logic                      esc_nxt;
  logic                      ovf_nxt;
  logic [NPOS-1:0]           lead_nxt;
  logic [NPOS-1:0]           act_nxt;
  logic [NPOS-1:0][1:0]      skip_nxt;
  logic                      out_vld_nxt;
  out_item_t                 out_nxt;

  logic                      proceed;
  logic                      do_append;
  token_t                    app_tok;
  logic [CW-1:0]             base_count;
  logic                      base_esc;
  logic                      base_ovf;
  logic [NPOS-1:0]           base_lead;
  logic [NPOS-1:0]           eng_act;
  logic [NPOS-1:0][1:0]      eng_skip;
  logic                      eng_hit;
  logic                      pat_err;

  // handshakes
  assign proceed   = in_vld_r && ((in_r.opcode != OP_END) || !out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || proceed;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  slpm_engine #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_engine (
    .utf8_mode  (utf8_r),
    .is_text    (in_r.opcode == OP_TEXT),
    .text_byte  (in_r.data_byte),
    .token_count(count_r),
    .tokens     (tok_r),
    .active     (act_r),
    .skip       (skip_r),
    .active_nxt (eng_act),
    .skip_nxt   (eng_skip),
    .hit        (eng_hit)
  );

  assign pat_err = esc_r || ovf_r;

  // pattern compile: pattern start drops the old pattern before this byte
  always_comb begin
    base_count = in_r.pattern_start ? '0 : count_r;
    base_esc   = in_r.pattern_start ? 1'b0 : esc_r;
    base_ovf   = in_r.pattern_start ? 1'b0 : ovf_r;
    base_lead  = in_r.pattern_start ? NPOS'(1) : lead_r;
    do_append  = 1'b1;
    esc_nxt    = 1'b0;
    app_tok.kind = KIND_LIT;
    app_tok.lit  = in_r.data_byte;
    if (base_esc) begin
      app_tok.kind = KIND_LIT;
    end else if (in_r.data_byte == CHAR_BACKSLASH) begin
      do_append = 1'b0;
      esc_nxt   = 1'b1;
    end else if (in_r.data_byte == CHAR_PERCENT) begin
      app_tok.kind = KIND_SEQ;
      app_tok.lit  = 8'd0;
    end else if (in_r.data_byte == CHAR_UNDERSCORE) begin
      app_tok.kind = KIND_ONE;
      app_tok.lit  = 8'd0;
    end
  end

  // next state per opcode
  always_comb begin
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    lead_nxt    = lead_r;
    act_nxt     = act_r;
    skip_nxt    = skip_r;
    out_vld_nxt = out_vld_r && !out_ready;
    out_nxt     = out_r;
    if (proceed) begin
      unique case (in_r.opcode)
        OP_PATTERN: begin
          count_nxt = base_count;
          ovf_nxt   = base_ovf;
          lead_nxt  = base_lead;
          if (do_append) begin
            if (base_count < CW'(PATTERN_MAX)) begin
              count_nxt = base_count + CW'(1);
              lead_nxt  = base_lead |
                          (NPOS'((app_tok.kind == KIND_SEQ) && base_lead[base_count])
                           << (base_count + CW'(1)));
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          act_nxt  = lead_nxt;
          skip_nxt = '0;
        end
        OP_TEXT: begin
          act_nxt  = eng_act;
          skip_nxt = eng_skip;
        end
        OP_END: begin
          out_vld_nxt           = 1'b1;
          out_nxt.matched       = eng_hit && !pat_err;
          out_nxt.pattern_error = pat_err;
          act_nxt               = lead_r;
          skip_nxt              = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control and position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf8_r    <= 1'b0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      count_r   <= '0;
      esc_r     <= 1'b0;
      ovf_r     <= 1'b0;
      lead_r    <= NPOS'(1);
      act_r     <= NPOS'(1);
      skip_r    <= '0;
    end else begin
      if (cfg_valid) begin
        utf8_r <= cfg_data;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
      if (proceed && (in_r.opcode == OP_PATTERN)) begin
        esc_r <= esc_nxt;
      end
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      lead_r  <= lead_nxt;
      act_r   <= act_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // payload registers and token store
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
    if (proceed && (in_r.opcode == OP_PATTERN) && do_append &&
        (base_count < CW'(PATTERN_MAX))) begin
      tok_r[base_count[IW-1:0]] <= app_tok;
    end
  end

  // checks
  `SLPM_ASSERT(a_count_range, count_r <= CW'(PATTERN_MAX), "token count beyond store")
  `SLPM_ASSERT(a_ovf_full, !ovf_r || (count_r == CW'(PATTERN_MAX)), "overflow with room left")
  `SLPM_ASSERT(a_lead_base, lead_r[0], "restart mask lost position zero")
  `SLPM_ASSERT_NEXT(a_end_hold, in_vld_r && (in_r.opcode == OP_END) && out_vld_r && !out_ready, in_vld_r && $stable(in_r), "end of text dropped while result stalled")

endmodule
